### rtl/far_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package far_pkg;
  localparam int InWidthDef = 32;
  localparam int MagW = 64;
  localparam int DenOutW = 62;
  localparam int ShW = 7;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_SUM,
    BK_GCD,
    BK_DIV,
    BK_DONE
  } bk_state_t;
endpackage
`default_nettype wire

### rtl/far_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface far_if #(parameter int W = 1) (input wire logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/fraction_add_reduce.sv
`timescale 1ns / 1ps
`default_nettype none
// Adds two fractions and reduces the sum by the gcd of its magnitudes. A
// two-entry queue decouples input from the back part, which handles one item
// at a time: a multiply, a binary gcd and two 64-bit restoring divisions. An
// item with a bad denominator skips the sum, gcd and divisions; a zero sum
// skips the gcd loop and the divisions.
module fraction_add_reduce #(
  parameter int IN_WIDTH = far_pkg::InWidthDef
) (
  input wire logic clk,
  input wire logic rst_n,
  far_if.sink      in_ch,
  far_if.source    out_ch
);
  import far_pkg::*;
  localparam int QW = 4 * IN_WIDTH + 1;
  logic q_valid, q_pop;
  logic [QW-1:0] q_data;
  logic [63:0] num;
  logic [61:0] den;
  logic bad;

  far_front #(.IN_WIDTH(IN_WIDTH), .QW(QW)) u_front (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .n1(in_ch.data[4*IN_WIDTH-3:3*IN_WIDTH-2]),
    .d1(in_ch.data[3*IN_WIDTH-3:2*IN_WIDTH-1]),
    .n2(in_ch.data[2*IN_WIDTH-2:IN_WIDTH-1]),
    .d2(in_ch.data[IN_WIDTH-2:0]),
    .q_valid, .q_pop, .q_data);

  far_back #(.IN_WIDTH(IN_WIDTH), .QW(QW)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_data,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .num, .den, .bad);

  assign out_ch.data = {num, den, bad};

  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && bad |-> num == '0 && den == 62'd1) else $error("bad");
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> den != '0) else $error("den");
endmodule
`default_nettype wire

### rtl/far_front.sv
`timescale 1ns / 1ps
`default_nettype none
module far_front #(
  parameter int IN_WIDTH = far_pkg::InWidthDef,
  parameter int QW = 4 * IN_WIDTH + 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [IN_WIDTH-1:0] n1,
  input  wire logic [IN_WIDTH-2:0] d1,
  input  wire logic [IN_WIDTH-1:0] n2,
  input  wire logic [IN_WIDTH-2:0] d2,
  output logic               q_valid,
  input  wire logic          q_pop,
  output logic [QW-1:0]      q_data
);
  // The front part splits the numerators into sign and magnitude and queues
  // the item; an item with a zero denominator is marked as bad.
  logic [QW-1:0] slot_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  logic [IN_WIDTH-1:0] m1, m2;
  logic [QW-1:0] ent;
  logic push;

  assign m1 = n1[IN_WIDTH-1] ? (~n1 + 1'b1) : n1;
  assign m2 = n2[IN_WIDTH-1] ? (~n2 + 1'b1) : n2;
  assign ent = {n1[IN_WIDTH-1], n2[IN_WIDTH-1], (d1 == '0) || (d2 == '0),
                m1, m2, d1, d2};
  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data = slot_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
    end
    if (push) slot_r[wp_r] <= ent;
  end
endmodule
`default_nettype wire

### rtl/far_back.sv
`timescale 1ns / 1ps
`default_nettype none
module far_back #(
  parameter int IN_WIDTH = far_pkg::InWidthDef,
  parameter int QW = 4 * IN_WIDTH + 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  output logic               q_pop,
  input  wire logic [QW-1:0] q_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [63:0]        num,
  output logic [61:0]        den,
  output logic               bad
);
  import far_pkg::*;
  localparam int W = IN_WIDTH;

  bk_state_t st_r, st_nxt;
  logic s1_r, s2_r, bad_r;
  logic [W-1:0] m1_r, m2_r;
  logic [W-2:0] d1_r, d2_r;
  logic [MagW-1:0] t1_r, t2_r, den_r, mag_r;
  logic neg_r;
  logic [MagW-1:0] ga_r, gb_r;
  logic [ShW-1:0] sh_r;
  logic gphase_r;
  logic [MagW-1:0] g_r;
  // Shared restoring divider, one quotient bit per cycle, two passes.
  logic [MagW-1:0] dv_q_r, dv_rem_r;
  logic [ShW-1:0] dv_cnt_r;
  logic dv_pass_r;
  logic [MagW-1:0] qmag_r;
  logic [MagW:0] rtrial;
  logic [MagW-1:0] res_num_r;
  logic [61:0] res_den_r;
  logic res_bad_r, ov_r;

  assign rtrial = {dv_rem_r, dv_q_r[MagW-1]} - {1'b0, g_r};
  assign q_pop = (st_r == BK_IDLE) && q_valid;
  assign out_valid = ov_r;
  assign num = res_num_r;
  assign den = res_den_r;
  assign bad = res_bad_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE: if (q_valid) st_nxt = BK_MUL;
      BK_MUL:  st_nxt = bad_r ? BK_DONE : BK_SUM;
      BK_SUM:  st_nxt = BK_GCD;
      BK_GCD:  if (mag_r == '0) st_nxt = BK_DONE;
               else if (gphase_r && gb_r == '0) st_nxt = BK_DIV;
      BK_DIV:  if (dv_pass_r && dv_cnt_r == ShW'(MagW - 1)) st_nxt = BK_DONE;
      BK_DONE: if (!ov_r || out_ready) st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == BK_DONE && (!ov_r || out_ready)) ov_r <= 1'b1;
      else if (out_valid && out_ready) ov_r <= 1'b0;
    end
    case (st_r)
      BK_IDLE: begin
        {s1_r, s2_r, bad_r, m1_r, m2_r, d1_r, d2_r} <= q_data;
      end
      BK_MUL: begin
        t1_r <= MagW'(m1_r) * MagW'(d2_r);
        t2_r <= MagW'(m2_r) * MagW'(d1_r);
        den_r <= MagW'(d1_r) * MagW'(d2_r);
      end
      BK_SUM: begin
        if (s1_r == s2_r) begin
          mag_r <= t1_r + t2_r; neg_r <= s1_r;
        end else if (t1_r >= t2_r) begin
          mag_r <= t1_r - t2_r; neg_r <= s1_r;
        end else begin
          mag_r <= t2_r - t1_r; neg_r <= s2_r;
        end
        gphase_r <= 1'b0;
        sh_r <= '0;
      end
      BK_GCD: begin
        if (!gphase_r) begin
          // Load on entry via sentinel: first cycle copies the operands.
          ga_r <= mag_r;
          gb_r <= den_r;
          gphase_r <= 1'b1;
          sh_r <= '0;
        end else if (!ga_r[0] && !gb_r[0]) begin
          ga_r <= ga_r >> 1; gb_r <= gb_r >> 1; sh_r <= sh_r + 1'b1;
        end else if (!ga_r[0]) begin
          ga_r <= ga_r >> 1;
        end else if (gb_r != '0) begin
          if (!gb_r[0]) gb_r <= gb_r >> 1;
          else if (ga_r > gb_r) begin
            ga_r <= gb_r; gb_r <= ga_r - gb_r;
          end else gb_r <= gb_r - ga_r;
        end
        g_r <= ga_r << sh_r;
        dv_q_r <= mag_r;
        dv_rem_r <= '0;
        dv_cnt_r <= '0;
        dv_pass_r <= 1'b0;
      end
      BK_DIV: begin
        if (dv_cnt_r == ShW'(MagW - 1) && !dv_pass_r) begin
          dv_pass_r <= 1'b1;
          qmag_r <= {dv_q_r[MagW-2:0], !rtrial[MagW]};
          dv_q_r <= den_r;
          dv_rem_r <= '0;
          dv_cnt_r <= '0;
        end else begin
          if (!rtrial[MagW]) begin
            dv_rem_r <= rtrial[MagW-1:0];
            dv_q_r <= {dv_q_r[MagW-2:0], 1'b1};
          end else begin
            dv_rem_r <= {dv_rem_r[MagW-2:0], dv_q_r[MagW-1]};
            dv_q_r <= {dv_q_r[MagW-2:0], 1'b0};
          end
          dv_cnt_r <= dv_cnt_r + 1'b1;
        end
      end
      BK_DONE: begin
        if (!ov_r || out_ready) begin
          if (bad_r || mag_r == '0) begin
            res_num_r <= '0; res_den_r <= 62'd1;
          end else begin
            res_num_r <= neg_r ? (~qmag_r + 1'b1) : qmag_r;
            res_den_r <= dv_q_r[61:0];
          end
          res_bad_r <= bad_r;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

### test/far_check.sv
`timescale 1ns / 1ps
module far_check (
  input  logic        clk,
  input  logic        rst_n,
  far_if              mon_in,
  far_if              mon_out,
  output int          errors,
  output int          outstanding
);
  typedef struct packed {
    logic signed [63:0] num;
    logic [61:0]        den;
    logic               bad;
  } fsum_t;

  fsum_t expected_sums[$];

  function automatic fsum_t reduce_sum(logic [31:0] n1, logic [30:0] d1,
                                       logic [31:0] n2, logic [30:0] d2);
    fsum_t r;
    logic [63:0] m1, m2, t1, t2, mag, den, a, b, t, g;
    logic neg1, neg2, neg;
    int sh;
    neg1 = n1[31];
    neg2 = n2[31];
    m1 = 64'(signed'(n1));
    m2 = 64'(signed'(n2));
    if (neg1) m1 = -m1;
    if (neg2) m2 = -m2;
    r.num = '0;
    r.den = 62'd1;
    r.bad = 1'b0;
    if (d1 == 0 || d2 == 0) begin
      r.bad = 1'b1;
      return r;
    end
    t1 = m1 * 64'(d2);
    t2 = m2 * 64'(d1);
    den = 64'(d1) * 64'(d2);
    if (neg1 == neg2) begin
      mag = t1 + t2;
      neg = neg1;
    end else if (t1 >= t2) begin
      mag = t1 - t2;
      neg = neg1;
    end else begin
      mag = t2 - t1;
      neg = neg2;
    end
    if (mag == 0) return r;
    a = mag;
    b = den;
    sh = 0;
    while (((a | b) & 64'd1) == 0) begin
      a = a >> 1;
      b = b >> 1;
      sh++;
    end
    while (a[0] == 1'b0) a = a >> 1;
    while (b != 0) begin
      while (b[0] == 1'b0) b = b >> 1;
      if (a > b) begin
        t = a;
        a = b;
        b = t;
      end
      b = b - a;
    end
    g = a << sh;
    mag = mag / g;
    den = den / g;
    r.num = neg ? -mag : mag;
    r.den = den[61:0];
    return r;
  endfunction

  assign outstanding = expected_sums.size();

  always @(posedge clk) begin
    fsum_t e, got;
    if (!rst_n) begin
      errors <= 0;
    end else begin
      if (mon_in.valid && mon_in.ready)
        expected_sums.push_back(reduce_sum(mon_in.data[125:94], mon_in.data[93:63],
                                           mon_in.data[62:31], mon_in.data[30:0]));
      if (mon_out.valid && mon_out.ready) begin
        got = mon_out.data;
        if (expected_sums.size() == 0) begin
          if (errors < 10) $display("unexpected result beat %0d/%0d bad=%0b",
                                    got.num, got.den, got.bad);
          errors <= errors + 1;
        end else begin
          e = expected_sums.pop_front();
          if (e != got) begin
            if (errors < 10)
              $display("expected %0d/%0d bad=%0b, got %0d/%0d bad=%0b",
                       e.num, e.den, e.bad, got.num, got.den, got.bad);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

### test/tb_fraction_add_reduce.sv
`timescale 1ns / 1ps
module tb_fraction_add_reduce;
  localparam int IdleLimit = 6000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   errors, outstanding, idle_cycles;

  far_if #(.W(126)) in_ch (clk);
  far_if #(.W(127)) out_ch (clk);

  fraction_add_reduce #(.IN_WIDTH(32)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  far_check chk (
    .clk(clk), .rst_n(rst_n), .mon_in(in_ch), .mon_out(out_ch),
    .errors(errors), .outstanding(outstanding)
  );

  always #10 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // The receiver alternates between stretches of steady readiness and stalls.
  int stall_mode = 0;
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_ch.ready = 1'b1;
      1: out_ch.ready = ($urandom_range(0, 3) != 0);
      default: out_ch.ready = ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("fraction_add_reduce: mismatch");
      $finish;
    end
  end

  function automatic logic [31:0] rand_num();
    case ($urandom_range(0, 5))
      0: return 32'sd2147483647;
      1: return 32'h8000_0000;
      2: return 32'(signed'($urandom_range(0, 40)) - 20);
      3: return $urandom_range(0, 1) ? 32'($urandom_range(0, 1000) * 6)
                                     : -32'($urandom_range(0, 1000) * 6);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_den();
    case ($urandom_range(0, 9))
      0: return 31'd0;
      1: return 31'h7fff_ffff;
      2: return 31'($urandom_range(1, 12));
      3: return 31'($urandom_range(1, 500) * 12);
      4: return 31'd1 << $urandom_range(0, 30);
      default: return 31'($urandom);
    endcase
  endfunction

  int burst_left = 0;

  task automatic send_beat(logic [31:0] n1, logic [30:0] d1, logic [31:0] n2,
                           logic [30:0] d2);
    int gap;
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.data = {n1, d1, n2, d2};
    do @(posedge clk); while (!in_ch.ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 30);
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  initial begin
    logic [31:0] n;
    logic [30:0] d;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_beat(32'sd1, 31'd2, 32'sd1, 31'd2);
    send_beat(32'sd1, 31'd3, -32'sd1, 31'd3);
    send_beat(32'sd0, 31'd5, 32'sd0, 31'd7);
    send_beat(32'sd5, 31'd0, 32'sd3, 31'd4);
    send_beat(32'sd5, 31'd4, 32'sd3, 31'd0);
    send_beat(32'sd0, 31'd0, 32'sd0, 31'd0);
    send_beat(32'h8000_0000, 31'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
    send_beat(32'sd2147483647, 31'h7fff_ffff, 32'sd2147483647, 31'h7fff_ffff);
    send_beat(32'h8000_0000, 31'd1, 32'sd2147483647, 31'd1);
    send_beat(32'sd2147483647, 31'd1, 32'sd2147483647, 31'd1);
    send_beat(32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1);
    send_beat(32'sd2147483647, 31'h7fff_fffe, -32'sd2147483647, 31'h7fff_ffff);
    send_beat(-32'sd1, 31'd1, -32'sd1, 31'd1);
    send_beat(-32'sd3, 31'd4, 32'sd1, 31'd4);
    send_beat(32'sd6, 31'd8, 32'sd10, 31'd12);
    send_beat(32'hffff_ffff, 31'h7fff_ffff, 32'sd1, 31'd1);
    send_beat(32'sd1, 31'h4000_0000, 32'sd1, 31'h4000_0000);
    send_beat(32'h5555_5555, 31'h2aaa_aaaa, 32'haaaa_aaaa, 31'h5555_5555);

    for (int i = 0; i < 1100; i++) begin
      if (i == 550) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (outstanding != 0) @(negedge clk);
      end
      if ($urandom_range(0, 9) == 0) begin
        n = rand_num();
        d = rand_den();
        send_beat(n, d, -n, d);
      end else begin
        send_beat(rand_num(), rand_den(), rand_num(), rand_den());
      end
    end
    @(negedge clk);
    in_ch.valid = 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("fraction_add_reduce: match");
    end else begin
      $display("fraction_add_reduce: mismatch");
    end
    $finish;
  end
endmodule
